>>> src/bubble_sorter_macros.svh
// ----------------------------------------------------------------------------
// Bubble sorter assertion macros
// Shared property shorthands for the sorter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORTER_MACROS_SVH
`define BUBBLE_SORTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define BS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bs_pkg.sv
// ----------------------------------------------------------------------------
// Bubble sorter package
// Word types, cell link types and sizing constants shared by the sorter.
// ----------------------------------------------------------------------------
package bs_pkg;

  localparam int VALUE_W      = 16;
  localparam int CAPACITY_DEF = 64;

  // Input word
  typedef struct packed {
    logic [VALUE_W-1:0] sample_value;
    logic               closes_set;
  } item_t;

  // Result word
  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               final_of_run;
    logic               overflowed;
  } result_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic               ins;
    logic               shift;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic               valid;
    logic               gt;
    logic [VALUE_W-1:0] value;
  } cell_tap_t;

endpackage

>>> src/bubble_sorter.sv
// ----------------------------------------------------------------------------
// Bubble sorter
// Collects a set of 16-bit words and returns them in ascending, stable order.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word on item with start high; it is taken when busy is low.
//   Collection takes one word per cycle: each word is placed in order at
//   once by a chain of CAPACITY compare cells, so the chain is always sorted.
//   Equal words keep their arrival order. Words arriving while the chain is
//   full are dropped and every result of that set carries overflowed.
//   The word with closes_set high ends the set: busy rises on the next cycle
//   and the chain drains from its low end, one result per cycle, each shown
//   for one cycle with strobe high. The first result is registered from
//   the head of the chain once busy is high, and the last one is marked
//   by final_of_run. Busy falls with the last result, so the next set may
//   start while it is shown. Every result leaves by the single drain port
//   at cell zero.
//   The receiver cannot stall; results must be taken as they appear.
//   Reset empties the chain and clears the count and the drop flag.
// ----------------------------------------------------------------------------
`include "bubble_sorter_macros.svh"

module bubble_sorter #(
  parameter int CAPACITY = bs_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bs_pkg::item_t   item,
  output logic            busy,
  output logic            strobe,
  output bs_pkg::result_t result
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]     fill;
  logic              drop;
  logic              accept;
  logic              room;
  bs_pkg::cell_ctl_t ctl;
  bs_pkg::cell_tap_t taps [CAPACITY];
  bs_pkg::cell_tap_t lefts [CAPACITY];
  bs_pkg::cell_tap_t rights [CAPACITY];

  assign accept = start && !busy;
  assign room   = (fill != CW'(CAPACITY));

  // Broadcast insert and drain controls
  assign ctl = '{ins: accept && room, shift: busy, value: item.sample_value};

  // Chain of cells, wired to their neighbors
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign lefts[gi] = '{valid: 1'b0, gt: 1'b0, value: '0};
      end else begin : g_mid_l
        assign lefts[gi] = taps[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign rights[gi] = '{valid: 1'b0, gt: 1'b1, value: '0};
      end else begin : g_mid_r
        assign rights[gi] = taps[gi+1];
      end
      bs_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .left  (lefts[gi]),
        .right (rights[gi]),
        .tap   (taps[gi])
      );
    end
  endgenerate

  // Sequence collection and drain, register results
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      drop   <= 1'b0;
      busy   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= busy;
      if (busy) begin
        fill <= fill - CW'(1);
        if (fill == CW'(1)) begin
          busy <= 1'b0;
          drop <= 1'b0;
        end
      end else if (accept) begin
        if (room) begin
          fill <= fill + CW'(1);
        end else begin
          drop <= 1'b1;
        end
        busy <= item.closes_set;
      end
    end
  end

  // Capture the head of the chain as it drains
  always_ff @(posedge clk) begin
    if (busy) begin
      result.sorted_value <= taps[0].value;
      result.final_of_run <= (fill == CW'(1));
      result.overflowed   <= drop;
    end
  end

  `BS_ASSERT_NOW(a_fill_bounded, clk, rst, 1'b1, fill <= CW'(CAPACITY),
    "fill count above capacity")
  `BS_ASSERT_NEXT(a_close_starts_drain, clk, rst, accept && item.closes_set, busy,
    "closing word did not start the drain")
  `BS_ASSERT_NOW(a_drain_not_empty, clk, rst, busy, fill != '0 && taps[0].valid,
    "drain with an empty chain")
  `BS_ASSERT_NOW(a_final_ends_busy, clk, rst, strobe && result.final_of_run, !busy,
    "still busy after the final result")

endmodule

>>> src/bs_cell.sv
// ----------------------------------------------------------------------------
// Bubble sorter cell
// One slot of the sorted chain: insert-with-shift-right, or shift left on drain.
// ----------------------------------------------------------------------------
module bs_cell (
  input  logic              clk,
  input  logic              rst,
  input  bs_pkg::cell_ctl_t ctl,
  input  bs_pkg::cell_tap_t left,
  input  bs_pkg::cell_tap_t right,
  output bs_pkg::cell_tap_t tap
);

  logic                       valid;
  logic [bs_pkg::VALUE_W-1:0] value;
  logic                       gt;

  // Empty slots count as larger than anything; ties keep the older word first
  assign gt  = !valid || (value > ctl.value);
  assign tap = '{valid: valid, gt: gt, value: value};

  // Hold occupancy; on insert take the left neighbor's mark or the new word's, on drain the right's
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins && gt) begin
      valid <= left.gt ? left.valid : 1'b1;
    end else if (ctl.shift) begin
      valid <= right.valid;
    end
  end

  // Take the left neighbor's word or the new word on insert; advance on drain
  always_ff @(posedge clk) begin
    if (ctl.ins && gt) begin
      value <= left.gt ? left.value : ctl.value;
    end else if (ctl.shift) begin
      value <= right.value;
    end
  end

endmodule
